>>> src/rfwm_pkg.sv
// ----------------------------------------------------------------------------
// rfwm_pkg: shared types and constants for the reverse flow window matcher
// Field widths and the request record that travels from front to back.
// ----------------------------------------------------------------------------
package rfwm_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned AddrW = 32;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic [TimeW-1:0] timestamp;
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic             ignored;
  } req_t;

  // Result record
  typedef struct packed {
    logic pair_found;
    logic ignored;
    logic overflow;
  } res_t;

endpackage

>>> src/reverse_flow_window_matcher_top.sv
// The back end takes a new request only when idle with no result waiting;
//   it scans the entry ring through its single read port, one entry at a time.
// The input queue takes two requests while the back end works.
// Reset: asynchronous, active low; empties window, interval reads zero.
// ----------------------------------------------------------------------------
// reverse_flow_window_matcher_top: reverse pair matcher over a time window
// Front end classifies requests, back end scans and updates the ring.
// ----------------------------------------------------------------------------
module reverse_flow_window_matcher_top #(
  parameter int unsigned WindowDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] timestamp_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pair_found_o,
  output logic        ignored_o,
  output logic        overflow_o
);
  import rfwm_pkg::*;

  logic [TimeW-1:0] interval_q;
  logic             req_valid, req_ready;
  req_t             req;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  // Hold the interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end

  rfwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .timestamp_i(timestamp_i),
    .src_addr_i (src_addr_i),
    .dst_addr_i (dst_addr_i),
    .req_valid_o(req_valid),
    .req_ready_i(req_ready),
    .req_o      (req)
  );

  rfwm_back #(.WindowDepth(WindowDepth)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .interval_i (interval_q),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign pair_found_o = res.pair_found;
  assign ignored_o    = res.ignored;
  assign overflow_o   = res.overflow;

  // An ignored result never reports a match or an overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ignored_o |-> !pair_found_o && !overflow_o)
    else $error("ignored result carries match or overflow");

  // The back end takes no request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !req_ready)
    else $error("back end ready with result pending");

  // A request taken by the back end leaves the result slot empty next cycle only if not ignored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && !req.ignored |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

>>> src/rfwm_ram.sv
// ----------------------------------------------------------------------------
// rfwm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfwm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/rfwm_front.sv
// ----------------------------------------------------------------------------
// rfwm_front: request intake, classification and two-entry queue
// Flags requests with a zero source or destination address and buffers all requests for the back end.
// ----------------------------------------------------------------------------
module rfwm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rfwm_pkg::TimeW-1:0] timestamp_i,
  input  logic [rfwm_pkg::AddrW-1:0] src_addr_i,
  input  logic [rfwm_pkg::AddrW-1:0] dst_addr_i,
  output logic                       req_valid_o,
  input  logic                       req_ready_i,
  output rfwm_pkg::req_t             req_o
);
  import rfwm_pkg::*;

  req_t       slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  req_t       new_req;

  // Classify the incoming request
  always_comb begin
    new_req.timestamp = timestamp_i;
    new_req.src_addr  = src_addr_i;
    new_req.dst_addr  = dst_addr_i;
    new_req.ignored   = (src_addr_i == '0) || (dst_addr_i == '0);
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= new_req;
    end
  end

endmodule

>>> src/rfwm_back.sv
// ----------------------------------------------------------------------------
// rfwm_back: window scan, eviction and append sequencer
// Reads the stored entries of the ring one at a time and drives one result.
// ----------------------------------------------------------------------------
module rfwm_back #(
  parameter int unsigned WindowDepth = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rfwm_pkg::TimeW-1:0] interval_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  rfwm_pkg::req_t             req_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output rfwm_pkg::res_t             res_o
);
  import rfwm_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowDepth);
  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam int unsigned EntW = TimeW + 2 * AddrW;
  localparam logic [CntW-1:0] DepthC = CntW'(WindowDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowDepth - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            cur_q, cur_d;
  logic [IdxW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] k_q, k_d;
  logic            evicting_q, evicting_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] nevict_q, nevict_d;
  logic [CntW-1:0] nevict_cnt_q, nevict_cnt_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic [IdxW-1:0] raddr, waddr;
  logic            we;
  logic [EntW-1:0] rdata, wdata;
  logic [TimeW-1:0] e_time, age;
  logic [AddrW-1:0] e_src, e_dst;
  logic            keep;

  // Ring index of oldest plus offset, wrapped
  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] base,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = {{(CntW+1-IdxW){1'b0}}, base} + {1'b0, off};
    if (s >= {1'b0, DepthC}) s = s - {1'b0, DepthC};
    return s[IdxW-1:0];
  endfunction

  rfwm_ram #(.Width(EntW), .Depth(WindowDepth)) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign {e_time, e_src, e_dst} = rdata;
  assign age  = (cur_q.timestamp >= e_time) ? cur_q.timestamp - e_time : '0;
  assign keep = (age <= interval_i);
  assign wdata = {cur_q.timestamp, cur_q.src_addr, cur_q.dst_addr};
  assign raddr = wrap(oldest_q, k_d);

  assign req_ready_o = (state_q == StIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Sequence one request: scan, evict, append, report; an ignored request is only reported
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    oldest_d     = oldest_q;
    count_d      = count_q;
    k_d          = k_q;
    evicting_d   = evicting_q;
    found_d      = found_q;
    nevict_d     = nevict_q;
    nevict_cnt_d = nevict_cnt_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = '0;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        k_d = '0;
        if (req_valid_i && req_ready_o) begin
          cur_d = req_i;
          if (req_i.ignored) begin
            res_valid_d = 1'b1;
            res_d       = '{pair_found: 1'b0, ignored: 1'b1, overflow: 1'b0};
          end else begin
            found_d      = 1'b0;
            evicting_d   = 1'b1;
            nevict_d     = oldest_q;
            nevict_cnt_d = count_q;
            state_d      = (count_q == '0) ? StDone : StRead;
          end
        end
      end
      StRead: begin
        // read of entry k issued; data valid next cycle
        state_d = StScan;
      end
      StScan: begin
        if (e_src == cur_q.dst_addr && e_dst == cur_q.src_addr && keep) found_d = 1'b1;
        if (evicting_q) begin
          if (keep) begin
            evicting_d = 1'b0;
          end else begin
            nevict_d     = (nevict_q == LastIdx) ? '0 : nevict_q + 1'b1;
            nevict_cnt_d = nevict_cnt_q - 1'b1;
          end
        end
        if (k_q + 1'b1 >= count_q) begin
          state_d = StDone;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = StRead;
        end
      end
      StDone: begin
        we = 1'b1;
        if (nevict_cnt_q >= DepthC) begin
          waddr    = nevict_q;
          oldest_d = (nevict_q == LastIdx) ? '0 : nevict_q + 1'b1;
          count_d  = DepthC;
        end else begin
          waddr    = wrap(nevict_q, nevict_cnt_q);
          oldest_d = nevict_q;
          count_d  = nevict_cnt_q + 1'b1;
        end
        res_valid_d = 1'b1;
        res_d = '{pair_found: found_q, ignored: 1'b0,
                  overflow: (nevict_cnt_q >= DepthC)};
        k_d     = '0;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      oldest_q    <= '0;
      count_q     <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold working payload
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    evicting_q   <= evicting_d;
    found_q      <= found_d;
    nevict_q     <= nevict_d;
    nevict_cnt_q <= nevict_cnt_d;
    res_q        <= res_d;
  end

endmodule
